// ===== rtl/kmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmf_pkg
// Shared widths, register indexes, queue item type and the k-mer hash helpers.
// ----------------------------------------------------------------------------
package kmf_pkg;

   localparam int BASE_W         = 8;
   localparam int HASH_W         = 30;
   localparam int POS_W          = 32;
   localparam int KLEN_W         = 4;
   localparam int WLEN_W         = 6;
   localparam int CSR_DATA_W     = 6;
   localparam int CSR_IDX_W      = 1;
   localparam int MAX_KMER       = 15;
   localparam int MAX_WINDOW_DEF = 32;

   localparam logic [CSR_IDX_W-1:0] REG_KMER_LEN   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LEN = 1'd1;

   localparam logic [KLEN_W-1:0] KMER_LEN_RST   = 4'd15;
   localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = 6'd10;

   localparam logic [BASE_W-1:0] CHAR_C_UP = 8'h43;
   localparam logic [BASE_W-1:0] CHAR_C_LO = 8'h63;
   localparam logic [BASE_W-1:0] CHAR_G_UP = 8'h47;
   localparam logic [BASE_W-1:0] CHAR_G_LO = 8'h67;
   localparam logic [BASE_W-1:0] CHAR_T_UP = 8'h54;
   localparam logic [BASE_W-1:0] CHAR_T_LO = 8'h74;

   typedef logic [HASH_W-1:0] hash_type;

   // one accepted request as handed from the front end to the back end
   typedef struct packed {
      hash_type              key;
      logic [KLEN_W-1:0]     k;
      logic [POS_W-1:0]      p;
      logic                  kmer_ok;
      logic                  seq_start;
   } kmf_item_type;

   function automatic logic [1:0] base_code(input logic [BASE_W-1:0] c);
      logic [1:0] code;
      unique case (c)
         CHAR_C_UP, CHAR_C_LO: code = 2'd1;
         CHAR_G_UP, CHAR_G_LO: code = 2'd2;
         CHAR_T_UP, CHAR_T_LO: code = 2'd3;
         default:              code = 2'd0;
      endcase
      return code;
   endfunction

   // low 2k bits set; k is 1..15
   function automatic hash_type kmer_mask(input logic [KLEN_W-1:0] k);
      hash_type full;
      full = '1;
      return ~(full << {k, 1'b0});
   endfunction

   // All steps run modulo 2^(2k): only the low 30 bits ever matter.
   function automatic hash_type hash_step_a(input hash_type key, input hash_type m);
      hash_type t;
      t = key & m;
      t = (~t + (t << 21)) & m;
      t = t ^ (t >> 24);
      return t;
   endfunction

   function automatic hash_type hash_step_b(input hash_type key, input hash_type m);
      hash_type t;
      t = ((key + (key << 3)) + (key << 8)) & m;
      t = t ^ (t >> 14);
      return t;
   endfunction

   // final key + (key << 31) term vanishes under a mask of 30 bits or less
   function automatic hash_type hash_step_c(input hash_type key, input hash_type m);
      hash_type t;
      t = ((key + (key << 2)) + (key << 4)) & m;
      t = t ^ (t >> 28);
      t = t & m;
      return t;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/kmf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmf_req_if / kmf_rsp_if
// Valid/ready channels for base requests and minimizer results.
// ----------------------------------------------------------------------------
interface kmf_req_if;
   import kmf_pkg::*;
   logic              valid;
   logic              ready;
   logic [BASE_W-1:0] base_char;
   logic              seq_start;

   modport source (output valid, output base_char, output seq_start, input ready);
   modport sink   (input valid, input base_char, input seq_start, output ready);
endinterface

interface kmf_rsp_if;
   import kmf_pkg::*;
   logic              valid;
   logic              ready;
   logic [HASH_W-1:0] min_hash;
   logic [POS_W-1:0]  min_pos;

   modport source (output valid, output min_hash, output min_pos, input ready);
   modport sink   (input valid, input min_hash, input min_pos, output ready);
endinterface
`default_nettype wire

// ===== rtl/kmf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmf_front
// Takes requests, codes the base, shifts the k-mer and counts positions.
// ----------------------------------------------------------------------------
module kmf_front (
   input  logic                        clock,
   input  logic                        reset,
   kmf_req_if.sink                     req_if,
   input  logic [kmf_pkg::KLEN_W-1:0]  k_eff,
   output logic                        push_valid,
   input  logic                        push_ready,
   output kmf_pkg::kmf_item_type       push_item
);
   import kmf_pkg::*;

   hash_type          shift_ff, shift_in, shift_base;
   logic [POS_W-1:0]  seen_ff, seen_in, seen_base;
   logic [1:0]        code;
   logic [4:0]        ins_pos;
   logic              accept;

   assign req_if.ready = push_ready;
   assign push_valid   = req_if.valid;
   assign accept       = req_if.valid && push_ready;

   always_comb begin
      shift_base = req_if.seq_start ? '0 : shift_ff;
      seen_base  = req_if.seq_start ? '0 : seen_ff;
      code       = base_code(req_if.base_char);
      ins_pos    = {k_eff - 4'd1, 1'b0};
      shift_in   = (shift_base >> 2) | (HASH_W'(code) << ins_pos);
      seen_in    = seen_base + 32'd1;

      push_item.key       = shift_in;
      push_item.k         = k_eff;
      push_item.p         = seen_in - POS_W'(k_eff);
      push_item.kmer_ok   = seen_in >= POS_W'(k_eff);
      push_item.seq_start = req_if.seq_start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         seen_ff  <= '0;
      end else if (accept) begin
         shift_ff <= shift_in;
         seen_ff  <= seen_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/kmf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmf_queue
// Two-entry queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module kmf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  kmf_pkg::kmf_item_type  push_item,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output kmf_pkg::kmf_item_type  pop_item
);
   import kmf_pkg::*;

   localparam logic [1:0] FULL_COUNT = 2'd2;

   kmf_item_type entries_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign count_in   = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_item;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT) else $error("queue count overflow");

   a_ptr_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == FULL_COUNT) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers out of step with count");

endmodule
`default_nettype wire

// ===== rtl/kmf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmf_back
// Hashes each k-mer, stores it in the window memory, scans a full window for
// its minimum and decides whether to emit a result.
// ----------------------------------------------------------------------------
module kmf_back #(
   parameter  int MAX_WINDOW = kmf_pkg::MAX_WINDOW_DEF,
   localparam int WIN_IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
   localparam int WIN_CNT_W  = $clog2(MAX_WINDOW + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  kmf_pkg::kmf_item_type  pop_item,
   input  logic [WIN_CNT_W-1:0]   w_eff,
   kmf_rsp_if.source              rsp_if
);
   import kmf_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_HASH_A = 6'b000010,
      S_HASH_B = 6'b000100,
      S_HASH_C = 6'b001000,
      S_SCAN   = 6'b010000,
      S_DECIDE = 6'b100000
   } back_state_type;

   back_state_type        state_ff, state_in;
   kmf_item_type          item_ff, item_in;
   hash_type              hash_ff, hash_in;
   hash_type              min_ff, min_in;
   logic [WIN_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  rd_vld_ff, rd_vld_in;
   hash_type              rd_data_ff;
   hash_type              mem_ff [MAX_WINDOW];
   logic [WIN_IDX_W-1:0]  slot_ff, slot_in, slot_cur, slot_nxt;
   logic [WIN_CNT_W-1:0]  slot_inc;
   hash_type              last_hash_ff, last_hash_in;
   logic [POS_W-1:0]      last_pos_ff, last_pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   hash_type              rsp_hash_ff, rsp_hash_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;

   hash_type              mask, hash_fin, fold_min;
   logic                  issue, rd_en, mem_we, need_emit, out_free, in_window;
   logic [WIN_IDX_W-1:0]  rd_addr;

   assign pop_ready       = state_ff == S_IDLE;
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.min_hash = rsp_hash_ff;
   assign rsp_if.min_pos  = rsp_pos_ff;

   always_comb begin
      mask      = kmer_mask(item_ff.k);
      hash_fin  = hash_step_c(hash_ff, mask);
      // slot past a shrunken window restarts at zero
      slot_cur  = (WIN_CNT_W'(slot_ff) >= w_eff) ? '0 : slot_ff;
      slot_inc  = WIN_CNT_W'(slot_cur) + WIN_CNT_W'(1);
      slot_nxt  = (slot_inc >= w_eff) ? '0 : slot_inc[WIN_IDX_W-1:0];
      issue     = cnt_ff < w_eff;
      rd_en     = (state_ff == S_SCAN) && issue;
      rd_addr   = cnt_ff[WIN_IDX_W-1:0];
      mem_we    = state_ff == S_HASH_C;
      fold_min  = (rd_data_ff < min_ff) ? rd_data_ff : min_ff;
      need_emit = (min_ff != last_hash_ff) ||
                  ((item_ff.p - last_pos_ff) >= POS_W'(w_eff));
      out_free  = !rsp_valid_ff || rsp_if.ready;
      in_window = item_ff.p >= (POS_W'(w_eff) - 32'd1);
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      hash_in      = hash_ff;
      min_in       = min_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = 1'b0;
      slot_in      = slot_ff;
      last_hash_in = last_hash_ff;
      last_pos_in  = last_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_hash_in  = rsp_hash_ff;
      rsp_pos_in   = rsp_pos_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               item_in = pop_item;
               if (pop_item.seq_start) begin
                  slot_in      = '0;
                  last_hash_in = '0;
                  last_pos_in  = '0;
               end
               if (pop_item.kmer_ok) state_in = S_HASH_A;
            end
         end
         S_HASH_A: begin
            hash_in  = hash_step_a(item_ff.key, mask);
            state_in = S_HASH_B;
         end
         S_HASH_B: begin
            hash_in  = hash_step_b(hash_ff, mask);
            state_in = S_HASH_C;
         end
         S_HASH_C: begin
            hash_in = hash_fin;
            slot_in = slot_nxt;
            if (in_window) begin
               min_in   = '1;
               cnt_in   = '0;
               state_in = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (rd_vld_ff) min_in = fold_min;
            rd_vld_in = issue;
            if (issue) cnt_in = cnt_ff + WIN_CNT_W'(1);
            else       state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!need_emit) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = min_ff;
               rsp_pos_in   = item_ff.p;
               last_hash_in = min_ff;
               last_pos_in  = item_ff.p;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         slot_ff      <= '0;
         last_hash_ff <= '0;
         last_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         slot_ff      <= slot_in;
         last_hash_ff <= last_hash_in;
         last_pos_ff  <= last_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      hash_ff     <= hash_in;
      min_ff      <= min_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_pos_ff  <= rsp_pos_in;
   end

   // window memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[slot_cur] <= hash_fin;
      if (rd_en)  rd_data_ff <= mem_ff[rd_addr];
   end

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (cnt_ff <= w_eff))
      else $error("window scan ran past the window");

   a_rd_follows_issue: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ($past(rd_en) && state_ff == S_SCAN))
      else $error("read data flagged without a scan read");

   a_emit_tracks_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && need_emit && out_free) |=>
      (rsp_valid_ff && rsp_hash_ff == last_hash_ff && rsp_pos_ff == last_pos_ff))
      else $error("emitted result and last minimizer disagree");

endmodule
`default_nettype wire

// ===== rtl/kmer_minimizer_stream_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmer_minimizer_stream_top
// Window minimizers over a nucleotide stream, one base per request.
// ----------------------------------------------------------------------------
// Each request carries one ASCII base; the block hashes the k-mer starting at
// every position, keeps the last window_len hashes and reports the window
// minimum, with the position of the newest k-mer, whenever it changes or
// window_len positions have passed since the previous report. The front end
// takes a request every cycle until its two-entry queue fills. The back end
// just pops a request that completes no k-mer; one whose position is still
// before the first full window passes the hash states S_HASH_A, S_HASH_B and
// S_HASH_C and is stored; any other then also scans the window memory over
// its single read port, one entry per cycle, and ends in a decision state.
// The scan sets the sustained rate. A finished result sits in an output
// register, so the back end keeps working while the result waits; it stalls
// only when a second result is ready before the first is taken.
// Configuration: csr index 0 is kmer_len (only the low four bits of a write
// are kept; 0 acts as 1), index 1 is window_len (0 acts as 1, above
// MAX_WINDOW acts as MAX_WINDOW). Write registers only while idle. Window
// entries never written since reset are not defined; a sequence must fill the window before its minimum is read.
// ----------------------------------------------------------------------------
module kmer_minimizer_stream_top #(
   parameter  int MAX_WINDOW = kmf_pkg::MAX_WINDOW_DEF,
   localparam int WIN_CNT_W  = $clog2(MAX_WINDOW + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [kmf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kmf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   kmf_req_if.sink                         req_if,
   kmf_rsp_if.source                       rsp_if
);
   import kmf_pkg::*;

   // configuration registers, kept as written
   logic [KLEN_W-1:0]     kmer_len_ff;
   logic [WLEN_W-1:0]     window_len_ff;

   // clamped values used by the datapath
   logic [KLEN_W-1:0]     k_eff;
   logic [WIN_CNT_W-1:0]  w_eff;

   // front end to queue, queue to back end
   logic                  push_valid, push_ready;
   kmf_item_type          push_item;
   logic                  pop_valid, pop_ready;
   kmf_item_type          pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_len_ff   <= KMER_LEN_RST;
         window_len_ff <= WINDOW_LEN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_KMER_LEN:   kmer_len_ff   <= csr_wdata[KLEN_W-1:0];
            REG_WINDOW_LEN: window_len_ff <= csr_wdata[WLEN_W-1:0];
         endcase
      end
   end

   always_comb begin
      priority if (kmer_len_ff == '0)            k_eff = KLEN_W'(1);
      else if (int'(kmer_len_ff) > MAX_KMER)     k_eff = KLEN_W'(MAX_KMER);
      else                                       k_eff = kmer_len_ff;

      priority if (window_len_ff == '0)          w_eff = WIN_CNT_W'(1);
      else if (int'(window_len_ff) > MAX_WINDOW) w_eff = WIN_CNT_W'(MAX_WINDOW);
      else                                       w_eff = WIN_CNT_W'(window_len_ff);
   end

   // base coding, k-mer shift register and position count
   kmf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .k_eff      (k_eff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   kmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // hash, window memory, minimum scan and result register
   kmf_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .w_eff      (w_eff),
      .rsp_if     (rsp_if)
   );

endmodule
`default_nettype wire
